/* rtl/core/smc_pkg.sv */
`timescale 1ns / 1ps

package smc_pkg;

    // Sample and store geometry
    localparam int SAMPLE_W    = 24;
    localparam int ADDR_W      = 15;
    localparam int DELAY_WORDS = 1 << ADDR_W;
    localparam int MAX_VOICES  = 6;
    localparam int N_W         = 3;
    localparam int BEAT_W      = N_W + 1;

    // LFO and sine table
    localparam int PHASE_W      = 32;
    localparam int SINE_AW      = 10;
    localparam int SINE_ENTRIES = 1 << SINE_AW;
    localparam int SINE_W       = 16;
    localparam logic [PHASE_W-1:0] SIXTH_TURN = 32'd715827883;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;

    // Delay arithmetic, frames in Q16
    localparam int FRAC_W      = 16;
    localparam int DLY_W       = 28;
    localparam int CODE_W      = 8;
    localparam int CODES       = 1 << CODE_W;
    localparam longint unsigned MIND_BASE   = 64'd131072;
    localparam longint unsigned MIND_SCALE  = 64'd73433088;
    localparam longint unsigned DEPTH_SCALE = 64'd7225344;
    localparam longint unsigned CODE_DEN    = 64'd240;
    localparam int MOD_W = DLY_W + 1 + SINE_W;
    localparam int PROD_W = SAMPLE_W + 1 + FRAC_W + 1;

    // Mix and divide
    localparam int SUM_W = 28;
    localparam int DIV_W = 32;
    localparam int DEN_W = 7;
    localparam int CNT_W = $clog2(DIV_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DELAY   = 3'd0,
        CFG_DEPTH       = 3'd1,
        CFG_PHASE_STEP  = 3'd2,
        CFG_TAP_COUNT   = 3'd3,
        CFG_RIGHT_PHASE = 3'd4
    } t_cfg_idx;

    typedef logic signed [SINE_W-1:0] t_sine_tab [SINE_ENTRIES];
    typedef logic [DLY_W-1:0]         t_dly_tab  [CODES];

    typedef struct packed {
        logic           take_in;
        logic           upd_empty;
        logic           issue;
        logic [N_W-1:0] voice;
        logic           lane;
        logic           div_start;
        logic           wr_left;
        logic           wr_right;
        logic           load_out;
        logic           out_silent;
    } t_cmd;

    typedef struct packed {
        logic           present;
        logic           silent_hit;
        logic [N_W-1:0] n;
        logic           pipe_busy;
        logic           div_busy;
    } t_sts;

    function automatic t_dly_tab mind_table();
        t_dly_tab tab;
        longint unsigned v;
        for (int c = 0; c < CODES; c++) begin
            v = MIND_BASE + (MIND_SCALE * longint'(c)) / CODE_DEN;
            tab[c] = DLY_W'(v);
        end
        return tab;
    endfunction

    function automatic t_dly_tab depth_table();
        t_dly_tab tab;
        longint unsigned v;
        for (int c = 0; c < CODES; c++) begin
            v = (DEPTH_SCALE * longint'(c)) / CODE_DEN;
            tab[c] = DLY_W'(v);
        end
        return tab;
    endfunction

    // Quadrant folding plus an odd Taylor series in Q30, up to x^11.
    function automatic t_sine_tab sine_table();
        t_sine_tab tab;
        longint unsigned q, r, u, x, x2, term, pos, neg, s, val;
        logic signed [SINE_W-1:0] sv;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            q = (4 * longint'(k)) / SINE_ENTRIES;
            r = 4 * longint'(k) - q * SINE_ENTRIES;
            u = q[0] ? SINE_ENTRIES - r : r;
            x = (HALF_PI_Q30 * u) / SINE_ENTRIES;
            x2 = (x * x) >> 30;
            // series terms x^3/3!, x^5/5!, ... built term by term
            term = ((x * x2) >> 30) / 64'd6;
            neg = term;
            term = ((term * x2) >> 30) / 64'd20;
            pos = x + term;
            term = ((term * x2) >> 30) / 64'd42;
            neg = neg + term;
            term = ((term * x2) >> 30) / 64'd72;
            pos = pos + term;
            term = ((term * x2) >> 30) / 64'd110;
            neg = neg + term;
            s = (pos > neg) ? pos - neg : 0;
            val = (s * 32767 + (64'd1 << 29)) >> 30;
            if (val > 32767) begin
                val = 32767;
            end
            sv = SINE_W'(val);
            tab[k] = (q >= 2) ? -sv : sv;
        end
        return tab;
    endfunction

endpackage

/* rtl/core/smc_if.sv */
`timescale 1ns / 1ps

interface smc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [smc_pkg::SAMPLE_W-1:0] in_left;
    logic signed [smc_pkg::SAMPLE_W-1:0] in_right;
    logic                                input_present;

    modport source (output valid, in_left, in_right, input_present, input ready);
    modport sink   (input valid, in_left, in_right, input_present, output ready);
endinterface

interface smc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [smc_pkg::SAMPLE_W-1:0] out_left;
    logic signed [smc_pkg::SAMPLE_W-1:0] out_right;
    logic                                silent;

    modport source (output valid, out_left, out_right, silent, input ready);
    modport sink   (input valid, out_left, out_right, silent, output ready);
endinterface

interface smc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [smc_pkg::CFG_IDX_W-1:0]     index;
    logic [smc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/smc_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, floor semantics for a
// signed numerator over a positive divisor.
module smc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [smc_pkg::DIV_W-1:0]   i_num,
    input  logic        [smc_pkg::DEN_W-1:0]   i_den,
    output logic                               o_busy,
    output logic signed [smc_pkg::DIV_W-1:0]   o_quot
);

    logic                           r_busy;
    logic [smc_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_neg;
    logic [smc_pkg::DIV_W-1:0]      r_q;
    logic [smc_pkg::DEN_W-1:0]      r_rem;
    logic [smc_pkg::DEN_W-1:0]      r_den;

    logic [smc_pkg::DEN_W:0]        trial;
    logic                           ge;
    logic [smc_pkg::DIV_W-1:0]      mag;

    assign trial = {r_rem, r_q[smc_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= smc_pkg::CNT_W'(smc_pkg::DIV_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[smc_pkg::DIV_W-1];
            r_q   <= i_num[smc_pkg::DIV_W-1] ? -i_num : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? smc_pkg::DEN_W'(trial - {1'b0, r_den}) : trial[smc_pkg::DEN_W-1:0];
            r_q   <= {r_q[smc_pkg::DIV_W-2:0], ge};
        end
    end

    // floor of a negative quotient rounds away from zero on a remainder
    assign mag    = r_q + smc_pkg::DIV_W'(r_rem != '0);
    assign o_quot = r_neg ? -$signed(mag) : $signed(r_q);
    assign o_busy = r_busy;

endmodule

/* rtl/core/smc_dp.sv */
`timescale 1ns / 1ps

module smc_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [smc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [smc_pkg::SAMPLE_W-1:0]   i_in_left,
    input  logic signed [smc_pkg::SAMPLE_W-1:0]   i_in_right,
    input  logic                                  i_input_present,
    input  smc_pkg::t_cmd                         i_cmd,
    output smc_pkg::t_sts                         o_sts,
    output logic signed [smc_pkg::SAMPLE_W-1:0]   o_out_left,
    output logic signed [smc_pkg::SAMPLE_W-1:0]   o_out_right,
    output logic                                  o_silent
);

    localparam smc_pkg::t_sine_tab SINE_ROM  = smc_pkg::sine_table();
    localparam smc_pkg::t_dly_tab  MIND_TAB  = smc_pkg::mind_table();
    localparam smc_pkg::t_dly_tab  DEPTH_TAB = smc_pkg::depth_table();
    localparam int SW = smc_pkg::SAMPLE_W;
    localparam logic signed [smc_pkg::DIV_W-1:0] SAT_HI = (1 <<< (SW - 1)) - 1;
    localparam logic signed [smc_pkg::DIV_W-1:0] SAT_LO = -(1 <<< (SW - 1));

    // configuration
    logic [smc_pkg::CODE_W-1:0]     r_min_code;
    logic [smc_pkg::CODE_W-1:0]     r_depth_code;
    logic [smc_pkg::PHASE_W-1:0]    r_phase_step;
    logic [smc_pkg::N_W-1:0]        r_tap_count;
    logic [smc_pkg::PHASE_W-1:0]    r_right_phase;

    // frame state
    logic [smc_pkg::ADDR_W-1:0]     r_wp;
    logic                           r_wrapped;
    logic [smc_pkg::PHASE_W-1:0]    r_lfo;
    logic [15:0]                    r_empty;

    // per-item registers
    logic signed [SW-1:0]           r_in_l, r_in_r;
    logic                           r_present;
    logic [smc_pkg::DLY_W-1:0]      r_avg, r_depth;
    logic [smc_pkg::N_W-1:0]        r_n;
    logic [smc_pkg::N_W-1:0]        n_eff;

    // voice pipeline
    logic [4:1]                     r_vld, r_lane;
    logic signed [smc_pkg::SINE_W-1:0] r_sine;
    logic signed [smc_pkg::MOD_W-1:0]  r_mod;
    logic signed [SW-1:0]           r_near_raw, r_far_raw;
    logic                           r_nv, r_fv;
    logic [smc_pkg::FRAC_W-1:0]     r_frac;
    logic signed [smc_pkg::PROD_W-1:0] r_prod;
    logic signed [SW-1:0]           r_near3;
    logic signed [smc_pkg::SUM_W-1:0]  r_acc_l, r_acc_r;

    logic signed [SW-1:0]           mem [smc_pkg::DELAY_WORDS];

    logic [smc_pkg::PHASE_W-1:0]    phase;
    logic signed [smc_pkg::MOD_W-1:0] mod_sh, dly_full;
    logic [smc_pkg::DLY_W-1:0]      dly;
    logic [smc_pkg::DLY_W-smc_pkg::FRAC_W-1:0] ip;
    logic [smc_pkg::ADDR_W-1:0]     off, base, a_near;
    logic signed [SW-1:0]           near_v, far_v;
    logic signed [SW:0]             diff;
    logic signed [smc_pkg::PROD_W-1:0] prod_sh;
    logic signed [smc_pkg::SUM_W-1:0]  voice;

    logic signed [smc_pkg::DIV_W-1:0] n_s, num_l, num_r, in_l_x, in_r_x, acc_l_x, acc_r_x;
    logic [smc_pkg::DEN_W-1:0]      den;
    logic                           busy_l, busy_r;
    logic signed [smc_pkg::DIV_W-1:0] quot_l, quot_r;
    logic [smc_pkg::ADDR_W-1:0]     wr_addr;
    logic signed [SW-1:0]           wr_data;

    always_comb begin
        if (r_tap_count < smc_pkg::N_W'(1) || r_tap_count > smc_pkg::N_W'(6) ||
            32'(r_tap_count) > smc_pkg::MAX_VOICES) begin
            n_eff = smc_pkg::N_W'(1);
        end else begin
            n_eff = r_tap_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_code    <= smc_pkg::CODE_W'(80);
            r_depth_code  <= smc_pkg::CODE_W'(90);
            r_phase_step  <= '0;
            r_tap_count   <= smc_pkg::N_W'(3);
            r_right_phase <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smc_pkg::CFG_MIN_DELAY:   r_min_code    <= i_cfg_data[smc_pkg::CODE_W-1:0];
                smc_pkg::CFG_DEPTH:       r_depth_code  <= i_cfg_data[smc_pkg::CODE_W-1:0];
                smc_pkg::CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data;
                smc_pkg::CFG_TAP_COUNT:   r_tap_count   <= i_cfg_data[smc_pkg::N_W-1:0];
                smc_pkg::CFG_RIGHT_PHASE: r_right_phase <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_lfo     <= '0;
            r_empty   <= '0;
            r_vld     <= '0;
        end else begin
            r_vld <= {r_vld[3:1], i_cmd.issue};
            if (i_cmd.upd_empty) begin
                if (r_present) begin
                    r_empty <= '0;
                end else if (r_empty != 16'hFFFF) begin
                    r_empty <= r_empty + 1'b1;
                end
            end
            if (i_cmd.wr_right) begin
                r_wp  <= r_wp + smc_pkg::ADDR_W'(2);
                r_lfo <= r_lfo + r_phase_step;
                if (r_wp == smc_pkg::ADDR_W'(smc_pkg::DELAY_WORDS - 2)) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_in_l    <= i_input_present ? i_in_left : '0;
            r_in_r    <= i_input_present ? i_in_right : '0;
            r_present <= i_input_present;
            r_depth   <= DEPTH_TAB[r_depth_code];
            r_avg     <= MIND_TAB[r_min_code] + DEPTH_TAB[r_depth_code];
            r_n       <= n_eff;
        end
    end

    // stage 0: voice phase and sine lookup
    assign phase = r_lfo + smc_pkg::PHASE_W'(smc_pkg::PHASE_W'(i_cmd.voice) * smc_pkg::SIXTH_TURN)
                 + (i_cmd.lane ? r_right_phase : '0);

    // stage 2: delay to store addresses
    assign mod_sh   = r_mod >>> (smc_pkg::SINE_W - 1);
    assign dly_full = $signed({{(smc_pkg::MOD_W-smc_pkg::DLY_W){1'b0}}, r_avg}) + mod_sh;
    assign dly      = dly_full[smc_pkg::MOD_W-1] ? '0 : dly_full[smc_pkg::DLY_W-1:0];
    assign ip       = dly[smc_pkg::DLY_W-1:smc_pkg::FRAC_W];
    assign off      = smc_pkg::ADDR_W'({ip, 1'b0});
    assign base     = r_wp + smc_pkg::ADDR_W'(r_lane[2]) - off;
    assign a_near   = base + smc_pkg::ADDR_W'(2);

    // stage 3: unwritten words read as zero
    assign near_v = r_nv ? r_near_raw : '0;
    assign far_v  = r_fv ? r_far_raw : '0;
    assign diff   = SW'(0) + {far_v[SW-1], far_v} - {near_v[SW-1], near_v};

    // stage 4
    assign prod_sh = r_prod >>> smc_pkg::FRAC_W;
    assign voice   = smc_pkg::SUM_W'(prod_sh) + smc_pkg::SUM_W'(r_near3);

    always_ff @(posedge i_clk) begin
        r_lane <= {r_lane[3:1], i_cmd.lane};
        r_sine <= SINE_ROM[phase[smc_pkg::PHASE_W-1 -: smc_pkg::SINE_AW]];
        r_mod  <= $signed({1'b0, r_depth}) * r_sine;
        r_frac <= dly[smc_pkg::FRAC_W-1:0];
        r_nv   <= r_wrapped || (a_near < r_wp);
        r_fv   <= r_wrapped || (base < r_wp);
        r_prod <= diff * $signed({1'b0, r_frac});
        r_near3 <= near_v;
        if (i_cmd.take_in) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_vld[4]) begin
            if (r_lane[4]) begin
                r_acc_r <= r_acc_r + voice;
            end else begin
                r_acc_l <= r_acc_l + voice;
            end
        end
    end

    // delay store: one write port, two registered read ports
    assign wr_addr = i_cmd.wr_right ? r_wp + smc_pkg::ADDR_W'(1) : r_wp;
    assign wr_data = i_cmd.wr_right ? r_in_r : r_in_l;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_left || i_cmd.wr_right) begin
            mem[wr_addr] <= wr_data;
        end
        r_near_raw <= mem[a_near];
        r_far_raw  <= mem[base];
    end

    // mix: floor((4n*in + 10*sum + 7n) / 14n)
    assign n_s     = $signed(smc_pkg::DIV_W'(r_n));
    assign in_l_x  = smc_pkg::DIV_W'(r_in_l);
    assign in_r_x  = smc_pkg::DIV_W'(r_in_r);
    assign acc_l_x = smc_pkg::DIV_W'(r_acc_l);
    assign acc_r_x = smc_pkg::DIV_W'(r_acc_r);
    assign num_l   = ((in_l_x * n_s) <<< 2) + (acc_l_x <<< 3) + (acc_l_x <<< 1)
                   + (n_s <<< 3) - n_s;
    assign num_r   = ((in_r_x * n_s) <<< 2) + (acc_r_x <<< 3) + (acc_r_x <<< 1)
                   + (n_s <<< 3) - n_s;
    assign den     = smc_pkg::DEN_W'({r_n, 3'b000}) + smc_pkg::DEN_W'({r_n, 2'b00})
                   + smc_pkg::DEN_W'({r_n, 1'b0});

    smc_div u_div_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_l),
        .i_den   (den),
        .o_busy  (busy_l),
        .o_quot  (quot_l)
    );

    smc_div u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_r),
        .i_den   (den),
        .o_busy  (busy_r),
        .o_quot  (quot_r)
    );

    function automatic logic signed [SW-1:0] sat(logic signed [smc_pkg::DIV_W-1:0] v);
        logic signed [SW-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[SW-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SW-1:0];
        end else begin
            res = v[SW-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_silent    <= i_cmd.out_silent;
            o_out_left  <= i_cmd.out_silent ? '0 : sat(quot_l);
            o_out_right <= i_cmd.out_silent ? '0 : sat(quot_r);
        end
    end

    always_comb begin
        o_sts.present    = r_present;
        o_sts.silent_hit = {r_empty, 16'h0000} >
                           (32'(r_avg) + 32'(r_depth));
        o_sts.n          = r_n;
        o_sts.pipe_busy  = |r_vld;
        o_sts.div_busy   = busy_l || busy_r;
    end

endmodule

/* rtl/core/smc_ctrl.sv */
`timescale 1ns / 1ps

module smc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  smc_pkg::t_sts   i_sts,
    output smc_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ISSUE,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WR_L,
        ST_WR_R,
        ST_FIN
    } t_state;

    t_state                         r_state;
    logic                           r_in_ready;
    logic                           r_out_valid;
    logic                           r_silent;
    logic [smc_pkg::BEAT_W-1:0]     r_beat;

    logic take_in, load_out, beat_last, go_silent;

    assign take_in   = i_in_valid && r_in_ready;
    assign load_out  = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);
    assign beat_last = r_beat == smc_pkg::BEAT_W'({i_sts.n, 1'b0} - 1'b1);
    assign go_silent = !i_sts.present && i_sts.silent_hit;

    always_comb begin
        o_cmd            = '0;
        o_cmd.take_in    = take_in;
        o_cmd.upd_empty  = (r_state == ST_CHECK) && !go_silent;
        o_cmd.issue      = r_state == ST_ISSUE;
        o_cmd.voice      = r_beat[smc_pkg::BEAT_W-1:1];
        o_cmd.lane       = r_beat[0];
        o_cmd.div_start  = r_state == ST_DIV_GO;
        o_cmd.wr_left    = r_state == ST_WR_L;
        o_cmd.wr_right   = r_state == ST_WR_R;
        o_cmd.load_out   = load_out;
        o_cmd.out_silent = r_silent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
            r_silent    <= 1'b0;
            r_beat      <= '0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (take_in) begin
                        r_in_ready <= 1'b0;
                        r_state    <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_silent <= go_silent;
                    r_beat   <= '0;
                    r_state  <= go_silent ? ST_FIN : ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (beat_last) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_beat <= r_beat + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (!i_sts.div_busy) begin
                        r_state <= ST_WR_L;
                    end
                end
                ST_WR_L: r_state <= ST_WR_R;
                ST_WR_R: r_state <= ST_FIN;
                ST_FIN: begin
                    if (load_out) begin
                        r_in_ready <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/stereo_multitap_chorus.sv */
`timescale 1ns / 1ps

// Stereo multi-voice chorus.
// Channels: i_in carries one stereo frame per transaction (in_left, in_right,
// input_present); o_out returns one mixed frame per transaction (out_left,
// out_right, silent); i_cfg writes one register per transaction, index 0..4
// (min delay code, depth code, phase step, tap count, right phase offset),
// always ready. Write registers only while no frame is in flight.
// A frame passes the voice pipeline, then the mix divide; a silent frame skips
// both. The voice pipeline issues one voice read per cycle (one per voice
// and channel, two store reads each), and the mix divide produces one
// quotient bit per cycle. A frame is taken only after the previous one has
// reached the output register.
// The result sits in an output register: the next frame is taken while it
// waits; a stalled receiver holds the block before the next result loads.
// Reset is synchronous; the delay store needs no clearing pass, since words
// not yet written since reset read as zero (tracked by write pointer and a
// wrap flag). Reset loads the default register values.
module stereo_multitap_chorus (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smc_in_if.sink    i_in,
    smc_out_if.source o_out,
    smc_cfg_if.sink   i_cfg
);

    smc_pkg::t_cmd cmd;
    smc_pkg::t_sts sts;

    // configuration port never stalls
    assign i_cfg.ready = 1'b1;

    smc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    smc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_idx       (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_in_left       (i_in.in_left),
        .i_in_right      (i_in.in_right),
        .i_input_present (i_in.input_present),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_left      (o_out.out_left),
        .o_out_right     (o_out.out_right),
        .o_silent        (o_out.silent)
    );

endmodule

/* rtl/core/smc_chk.sv */
`timescale 1ns / 1ps

module smc_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_out_silent,
    input logic signed [smc_pkg::SAMPLE_W-1:0] i_out_left,
    input logic signed [smc_pkg::SAMPLE_W-1:0] i_out_right
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a frame is in flight");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_silent |-> i_out_left == '0 && i_out_right == '0)
        else $error("silent frame with nonzero output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("handshake not idle after reset");

endmodule

bind stereo_multitap_chorus smc_chk u_smc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_silent (o_out.silent),
    .i_out_left   (o_out.out_left),
    .i_out_right  (o_out.out_right)
);
